[hw/rtl/cfbf_pkg.sv]
// shared types, register map and defaults for the csv field boundary finder
`default_nettype none

package cfbf_pkg;

    // default sizing handed to the top level parameters
    localparam int OFFSET_BITS_DEF = 24;
    localparam int MAX_COLUMNS_DEF = 4096;

    // fixed field widths
    localparam int BYTE_BITS   = 8;
    localparam int ROWS_BITS   = 24;
    localparam int COLS_BITS   = 13;
    localparam int OUT_OFFSET_BITS = 24;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 5;
    localparam int INDEX_BITS  = 3;

    // register indexes (byte address is 4 * index)
    typedef enum logic [INDEX_BITS-1:0] {
        REG_SEPARATOR = 3'd0,
        REG_ROW_DELIM = 3'd1,
        REG_QUOTE     = 3'd2,
        REG_ESCAPE    = 3'd3,
        REG_ROWS      = 3'd4,
        REG_COLUMNS   = 3'd5
    } t_reg_index;

    // reset values of the registers
    localparam logic [BYTE_BITS-1:0] SEPARATOR_RST = 8'd44;
    localparam logic [BYTE_BITS-1:0] ROW_DELIM_RST = 8'd10;
    localparam logic [BYTE_BITS-1:0] QUOTE_RST     = 8'd34;
    localparam logic [BYTE_BITS-1:0] ESCAPE_RST    = 8'd34;
    localparam logic [ROWS_BITS-1:0] ROWS_RST      = 24'd65535;
    localparam logic [COLS_BITS-1:0] COLUMNS_RST   = 13'd1;

    // configuration seen by the scanner
    typedef struct packed {
        logic [BYTE_BITS-1:0] separator;
        logic [BYTE_BITS-1:0] row_delim;
        logic [BYTE_BITS-1:0] quote;
        logic [BYTE_BITS-1:0] escape;
        logic [ROWS_BITS-1:0] rows_per_chunk;
        logic [COLS_BITS-1:0] columns_per_row;
    } t_cfg;

endpackage

`default_nettype wire

[hw/rtl/csv_field_boundary_finder.sv]
// top level of the csv field boundary finder: byte register, scan logic, result register
//
//   channel   direction  handshake                   word
//   text in   input      i_in_valid / o_in_ready     i_text_byte
//   boundary  output     o_out_valid / i_out_ready   offset, row_end, chunk_end, mismatch
//   config    input      psel / penable / pready     apb write, read via prdata
//
// one byte per cycle unless a field end waits for the result register; a byte
// goes from the input register through a few byte compares and counter updates
// into the result register, so a result is valid the cycle after the edge that
// moves its byte out of the input register. synchronous active-low reset clears
// all scan state, both valid flags and the config registers, not the payloads.
// a byte that ends no field moves on even while a result waits downstream; a byte
// that ends a field waits in the input register until the result register is free.
`default_nettype none

module csv_field_boundary_finder #(
    parameter int OFFSET_BITS = cfbf_pkg::OFFSET_BITS_DEF,
    parameter int MAX_COLUMNS = cfbf_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [cfbf_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [cfbf_pkg::DATA_BITS-1:0]       pwdata,
    output logic      [cfbf_pkg::DATA_BITS-1:0]       prdata,
    output logic                                      pready,
    // text input
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [cfbf_pkg::BYTE_BITS-1:0]       i_text_byte,
    // boundary output
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic      [cfbf_pkg::OUT_OFFSET_BITS-1:0] o_field_end_offset,
    output logic                                      o_row_end,
    output logic                                      o_chunk_end,
    output logic                                      o_column_mismatch
);
    import cfbf_pkg::*;

    // field counter holds up to MAX_COLUMNS + 1
    localparam int FW = $clog2(MAX_COLUMNS + 2);
    localparam int CW = (FW > COLS_BITS) ? FW : COLS_BITS;
    localparam logic [FW-1:0] FIELDS_SAT = FW'(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] COLS_MAX   = CW'(MAX_COLUMNS);

    t_cfg w_cfg;

    cfbf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register
    logic                   r_in_valid;
    logic [BYTE_BITS-1:0]   r_in_byte;

    // scan state
    logic                   r_quoted,     n_quoted;
    logic [BYTE_BITS-1:0]   r_prev_byte,  n_prev_byte;
    logic                   r_at_start,   n_at_start;
    logic [OFFSET_BITS-1:0] r_offset,     n_offset;
    logic [FW-1:0]          r_fields,     n_fields;
    logic [ROWS_BITS-1:0]   r_rows,       n_rows;

    // result register
    logic                       r_out_valid;
    logic [OUT_OFFSET_BITS-1:0] r_out_offset;
    logic                       r_out_row_end;
    logic                       r_out_chunk_end;
    logic                       r_out_mismatch;

    logic                 w_is_sep, w_is_del, w_is_quote, w_escaped;
    logic                 w_quotes_after, w_row_done, w_has_res, w_close;
    logic                 w_mismatch, w_advance, w_out_free;
    logic [ROWS_BITS-1:0] w_rows_inc;
    logic [CW-1:0]        w_cols, w_expect;
    logic [FW-1:0]        w_fields_base;

    // byte roles and quote tracking
    assign w_is_sep   = (r_in_byte == w_cfg.separator);
    assign w_is_del   = (r_in_byte == w_cfg.row_delim);
    assign w_is_quote = (r_in_byte == w_cfg.quote);
    assign w_escaped  = (w_cfg.quote != w_cfg.escape) && !r_at_start
                        && (r_prev_byte == w_cfg.escape);
    assign w_quotes_after = (w_is_quote && !w_escaped) ? !r_quoted : r_quoted;

    // row completion and chunk close
    assign w_row_done = w_is_del && !w_quotes_after;
    assign w_rows_inc = r_rows + 1'b1;
    assign w_close    = w_row_done && (w_cfg.rows_per_chunk != '0)
                        && (w_rows_inc >= w_cfg.rows_per_chunk);
    assign w_cols     = CW'(w_cfg.columns_per_row);
    assign w_expect   = (w_cols > COLS_MAX) ? COLS_MAX : w_cols;
    assign w_mismatch = (CW'(r_fields) != w_expect);

    // a field ends on separator or delimiter outside quotes, never on a quote
    assign w_has_res  = (w_is_sep || w_is_del) && !w_quotes_after && !w_is_quote;

    // flow control
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_has_res || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    // next scan state
    always_comb begin
        n_quoted      = r_quoted;
        n_prev_byte   = r_prev_byte;
        n_at_start    = r_at_start;
        n_offset      = r_offset;
        n_fields      = r_fields;
        n_rows        = r_rows;
        w_fields_base = w_row_done ? '0 : r_fields;
        if (w_advance) begin
            n_quoted    = w_quotes_after;
            n_prev_byte = r_in_byte;
            n_rows      = w_row_done ? w_rows_inc : r_rows;
            n_fields    = (w_has_res && (w_fields_base < FIELDS_SAT))
                          ? w_fields_base + 1'b1 : w_fields_base;
            if (w_close) begin
                n_quoted    = 1'b0;
                n_at_start  = 1'b1;
                n_offset    = '0;
                n_fields    = FW'(1);
                n_rows      = '0;
            end else begin
                n_at_start  = 1'b0;
                n_offset    = r_offset + 1'b1;
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_quoted    <= 1'b0;
            r_prev_byte <= '0;
            r_at_start  <= 1'b1;
            r_offset    <= '0;
            r_fields    <= FW'(1);
            r_rows      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance && w_has_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_quoted    <= n_quoted;
            r_prev_byte <= n_prev_byte;
            r_at_start  <= n_at_start;
            r_offset    <= n_offset;
            r_fields    <= n_fields;
            r_rows      <= n_rows;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
        if (w_advance && w_has_res) begin
            r_out_offset    <= OUT_OFFSET_BITS'(r_offset);
            r_out_row_end   <= w_row_done;
            r_out_chunk_end <= w_close;
            r_out_mismatch  <= w_row_done && w_mismatch;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_field_end_offset = r_out_offset;
    assign o_row_end          = r_out_row_end;
    assign o_chunk_end        = r_out_chunk_end;
    assign o_column_mismatch  = r_out_mismatch;

endmodule

`default_nettype wire

[hw/rtl/cfbf_regs.sv]
// apb-style configuration registers of the csv field boundary finder
`default_nettype none

module cfbf_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cfbf_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [cfbf_pkg::DATA_BITS-1:0] pwdata,
    output logic      [cfbf_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready,
    output cfbf_pkg::t_cfg                      o_cfg
);
    import cfbf_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = t_reg_index'(paddr[ADDR_BITS-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                REG_SEPARATOR: n_cfg.separator       = pwdata[BYTE_BITS-1:0];
                REG_ROW_DELIM: n_cfg.row_delim       = pwdata[BYTE_BITS-1:0];
                REG_QUOTE:     n_cfg.quote           = pwdata[BYTE_BITS-1:0];
                REG_ESCAPE:    n_cfg.escape          = pwdata[BYTE_BITS-1:0];
                REG_ROWS:      n_cfg.rows_per_chunk  = pwdata[ROWS_BITS-1:0];
                REG_COLUMNS:   n_cfg.columns_per_row = pwdata[COLS_BITS-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator       <= SEPARATOR_RST;
            r_cfg.row_delim       <= ROW_DELIM_RST;
            r_cfg.quote           <= QUOTE_RST;
            r_cfg.escape          <= ESCAPE_RST;
            r_cfg.rows_per_chunk  <= ROWS_RST;
            r_cfg.columns_per_row <= COLUMNS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        case (w_index)
            REG_SEPARATOR: prdata = DATA_BITS'(r_cfg.separator);
            REG_ROW_DELIM: prdata = DATA_BITS'(r_cfg.row_delim);
            REG_QUOTE:     prdata = DATA_BITS'(r_cfg.quote);
            REG_ESCAPE:    prdata = DATA_BITS'(r_cfg.escape);
            REG_ROWS:      prdata = DATA_BITS'(r_cfg.rows_per_chunk);
            REG_COLUMNS:   prdata = DATA_BITS'(r_cfg.columns_per_row);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
